@@ design/sgcf_pkg.sv @@
// shared types, constants and helpers for the small graph canonical form block
// no dependencies; used by sgcf_ctrl, sgcf_dp and small_graph_canonical_form
package sgcf_pkg;

  localparam int NV = 7;                 // vertices handled
  localparam int VW = 3;                 // vertex index width
  localparam int NP = NV * (NV - 1) / 2; // vertex pairs in the edge mask
  localparam int CW = 13;                // automorphism count width
  localparam int QW = 5;                 // pair index width

  typedef logic [VW-1:0] vtx_t;
  typedef logic [NP-1:0] code_t;
  typedef logic [QW-1:0] pidx_t;

  typedef struct packed {
    logic [NP-1:0] graph_code;
    logic [VW-1:0] vertex_count;
  } in_item_t;

  typedef struct packed {
    logic [NP-1:0] canonical_code;
    logic [CW-1:0] automorphism_count;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic publish;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
  } dp_stat_t;

  // mask of the pair bits in use for a given vertex count
  function automatic code_t pair_mask(input vtx_t n);
    code_t m;
    case (n)
      3'd2:    m = code_t'(21'h000001);
      3'd3:    m = code_t'(21'h000007);
      3'd4:    m = code_t'(21'h00003F);
      3'd5:    m = code_t'(21'h0003FF);
      3'd6:    m = code_t'(21'h007FFF);
      3'd7:    m = code_t'(21'h1FFFFF);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ design/sgcf_dp.sv @@
// datapath: graph registers, degree classes, vertex order walker and result accumulators
// depends on sgcf_pkg
module sgcf_dp (
  input  logic                clk,
  input  sgcf_pkg::in_item_t  in_item,
  input  sgcf_pkg::dp_cmd_t   cmd,
  output sgcf_pkg::dp_stat_t  stat,
  output sgcf_pkg::out_item_t out_item
);

  sgcf_pkg::code_t                   mask;
  sgcf_pkg::vtx_t                    nv;
  sgcf_pkg::vtx_t                    deg  [sgcf_pkg::NV];
  sgcf_pkg::vtx_t                    sdeg [sgcf_pkg::NV];
  sgcf_pkg::vtx_t                    perm [sgcf_pkg::NV];
  sgcf_pkg::code_t                   best;
  logic [sgcf_pkg::CW-1:0]           cnt;

  logic                              adj    [sgcf_pkg::NV][sgcf_pkg::NV];
  sgcf_pkg::vtx_t                    deg_c  [sgcf_pkg::NV];
  sgcf_pkg::vtx_t                    rank_c [sgcf_pkg::NV];
  sgcf_pkg::vtx_t                    sdeg_c [sgcf_pkg::NV];
  sgcf_pkg::code_t                   code_c;
  logic                              ok_c;
  logic                              found;
  sgcf_pkg::vtx_t                    piv;
  sgcf_pkg::vtx_t                    swp;
  sgcf_pkg::vtx_t                    tmp    [sgcf_pkg::NV];
  sgcf_pkg::vtx_t                    perm_next [sgcf_pkg::NV];

  // adjacency matrix from the stored mask, pairs numbered over the vertices in use
  always_comb begin
    sgcf_pkg::pidx_t q;
    q = '0;
    for (int a = 0; a < sgcf_pkg::NV; a++) begin
      for (int b = 0; b < sgcf_pkg::NV; b++) begin
        adj[a][b] = 1'b0;
      end
    end
    for (int i = 0; i < sgcf_pkg::NV; i++) begin
      for (int j = i + 1; j < sgcf_pkg::NV; j++) begin
        if (sgcf_pkg::vtx_t'(j) < nv) begin
          adj[i][j] = mask[q];
          adj[j][i] = mask[q];
          q = q + sgcf_pkg::pidx_t'(1);
        end
      end
    end
  end

  // degrees, stable rank by degree and sorted degree sequence
  always_comb begin
    for (int v = 0; v < sgcf_pkg::NV; v++) begin
      deg_c[v] = '0;
      for (int u = 0; u < sgcf_pkg::NV; u++) begin
        deg_c[v] = deg_c[v] + sgcf_pkg::vtx_t'(adj[v][u]);
      end
    end
    for (int v = 0; v < sgcf_pkg::NV; v++) begin
      rank_c[v] = '0;
      for (int u = 0; u < sgcf_pkg::NV; u++) begin
        if (sgcf_pkg::vtx_t'(u) < nv &&
            (deg_c[u] < deg_c[v] || (deg_c[u] == deg_c[v] && u < v))) begin
          rank_c[v] = rank_c[v] + 1'b1;
        end
      end
    end
    for (int p = 0; p < sgcf_pkg::NV; p++) begin
      sdeg_c[p] = '0;
      for (int v = 0; v < sgcf_pkg::NV; v++) begin
        if (sgcf_pkg::vtx_t'(v) < nv && rank_c[v] == sgcf_pkg::vtx_t'(p)) begin
          sdeg_c[p] = sdeg_c[p] | deg_c[v];
        end
      end
    end
  end

  // re-encode the mask under the current order and check the order keeps classes
  always_comb begin
    sgcf_pkg::pidx_t q;
    q = '0;
    code_c = '0;
    for (int i = 0; i < sgcf_pkg::NV; i++) begin
      for (int j = i + 1; j < sgcf_pkg::NV; j++) begin
        if (sgcf_pkg::vtx_t'(j) < nv) begin
          code_c[q] = adj[perm[i]][perm[j]];
          q = q + sgcf_pkg::pidx_t'(1);
        end
      end
    end
    ok_c = 1'b1;
    for (int p = 0; p < sgcf_pkg::NV; p++) begin
      if (sgcf_pkg::vtx_t'(p) < nv) begin
        if (!(perm[p] < nv && deg[perm[p]] == sdeg[p])) ok_c = 1'b0;
      end else begin
        if (perm[p] != sgcf_pkg::vtx_t'(p)) ok_c = 1'b0;
      end
    end
  end

  // lexicographic next order: pivot, swap, reverse the tail
  always_comb begin
    found = 1'b0;
    piv   = '0;
    for (int i = 0; i < sgcf_pkg::NV - 1; i++) begin
      if (perm[i] < perm[i+1]) begin
        found = 1'b1;
        piv   = sgcf_pkg::vtx_t'(i);
      end
    end
    swp = piv;
    for (int j = 0; j < sgcf_pkg::NV; j++) begin
      if (sgcf_pkg::vtx_t'(j) > piv && perm[j] > perm[piv]) swp = sgcf_pkg::vtx_t'(j);
    end
    for (int k = 0; k < sgcf_pkg::NV; k++) begin
      tmp[k] = perm[k];
    end
    tmp[piv] = perm[swp];
    tmp[swp] = perm[piv];
    for (int k = 0; k < sgcf_pkg::NV; k++) begin
      if (sgcf_pkg::vtx_t'(k) > piv) begin
        perm_next[k] = tmp[3'(4'(piv) + 4'(sgcf_pkg::NV) - 4'(k))];
      end else begin
        perm_next[k] = tmp[k];
      end
    end
  end

  assign stat.last = !found;

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask <= in_item.graph_code & sgcf_pkg::pair_mask(in_item.vertex_count);
      nv   <= in_item.vertex_count;
      best <= '1;
      cnt  <= '0;
      for (int k = 0; k < sgcf_pkg::NV; k++) begin
        perm[k] <= sgcf_pkg::vtx_t'(k);
      end
    end
    if (cmd.prep) begin
      for (int k = 0; k < sgcf_pkg::NV; k++) begin
        deg[k]  <= deg_c[k];
        sdeg[k] <= sdeg_c[k];
      end
    end
    if (cmd.step) begin
      if (ok_c) begin
        if (code_c < best) best <= code_c;
        if (code_c == mask) cnt <= cnt + 1'b1;
      end
      for (int k = 0; k < sgcf_pkg::NV; k++) begin
        perm[k] <= perm_next[k];
      end
    end
    if (cmd.publish) begin
      out_item.canonical_code     <= best;
      out_item.automorphism_count <= cnt;
    end
  end

endmodule

@@ design/sgcf_ctrl.sv @@
// controller: sequences load, class set-up, the order walk and the result hand-off
// depends on sgcf_pkg
module sgcf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sgcf_pkg::dp_stat_t stat,
  output sgcf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {IDLE, PREP, RUN, DONE} state_t;

  state_t state;

  // commands decoded from state
  assign in_stall    = (state != IDLE);
  assign cmd.load    = in_valid && (state == IDLE);
  assign cmd.prep    = (state == PREP);
  assign cmd.step    = (state == RUN);
  assign cmd.publish = (state == DONE) && (!out_valid || !out_stall);

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) state <= PREP;
        end
        PREP: begin
          state <= RUN;
        end
        RUN: begin
          if (stat.last) state <= DONE;
        end
        DONE: begin
          if (cmd.publish) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ design/small_graph_canonical_form.sv @@
// top level of the small graph canonical form block
// depends on sgcf_pkg, sgcf_ctrl and sgcf_dp
//
// Takes a graph on up to seven vertices as an upper-triangle edge mask and returns
// the smallest mask over all vertex orders that permute only within degree classes,
// plus the number of such orders that reproduce the input mask. After acceptance, the
// PREP state forms the degree classes, then the order walker steps through all 5040
// orders of seven positions at one re-encode and compare per cycle, and the DONE state
// loads the output register. The next item is accepted from the cycle after that load,
// while the result waits; if the earlier result is still waiting when a walk ends, the
// load and so the next acceptance wait until it is taken.
module small_graph_canonical_form (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sgcf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sgcf_pkg::out_item_t out_item
);

  sgcf_pkg::dp_cmd_t  cmd;
  sgcf_pkg::dp_stat_t stat;

  // sequencing
  sgcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // enumeration and accumulation
  sgcf_dp u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

@@ tb/tb.sv @@
// testbench for small_graph_canonical_form: directed table, then random graphs
// depends on sgcf_pkg and the small_graph_canonical_form rtl
`timescale 1ns / 100ps

module tb;

  localparam int  LIMIT_CYCLES = 4000000;
  localparam int  HOLD_CYCLES  = 12000;
  localparam int  RANDOM_ITEMS = 90;
  localparam int  DRAIN_CYCLES = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sgcf_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  sgcf_pkg::out_item_t out_item;

  small_graph_canonical_form dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sgcf_pkg::out_item_t expected_labels[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        labels_seen = 0;
  int        cycle_count = 0;
  int        idle_phase = 0;
  bit        sending_done = 0;

  // predictor scratch state
  bit  g_adj[sgcf_pkg::NV][sgcf_pkg::NV];
  int  g_n;
  int  g_sorted[sgcf_pkg::NV];
  int  g_lo[sgcf_pkg::NV];
  int  g_hi[sgcf_pkg::NV];
  int  g_order[sgcf_pkg::NV];
  bit  g_used[sgcf_pkg::NV];
  sgcf_pkg::code_t g_best;
  sgcf_pkg::code_t g_target;
  int  g_hits;

  function automatic sgcf_pkg::code_t encode_order();
    sgcf_pkg::code_t x;
    int q;
    x = '0;
    q = 0;
    for (int i = 0; i < g_n; i++)
      for (int j = i + 1; j < g_n; j++) begin
        if (g_adj[g_order[i]][g_order[j]]) x[q] = 1'b1;
        q++;
      end
    return x;
  endfunction

  // try every order that stays within degree classes
  function automatic void walk_orders(int pos);
    sgcf_pkg::code_t x;
    int v;
    if (pos >= g_n) begin
      x = encode_order();
      if (x < g_best) g_best = x;
      if (x == g_target) g_hits++;
      return;
    end
    for (int k = g_lo[pos]; k < g_hi[pos]; k++) begin
      v = g_sorted[k];
      if (!g_used[v]) begin
        g_used[v] = 1'b1;
        g_order[pos] = v;
        walk_orders(pos + 1);
        g_used[v] = 1'b0;
      end
    end
  endfunction

  function automatic sgcf_pkg::out_item_t canonical_label(sgcf_pkg::in_item_t it);
    sgcf_pkg::out_item_t r;
    int deg[sgcf_pkg::NV];
    int q, v, k, lo;
    sgcf_pkg::code_t m;
    g_n = it.vertex_count;
    m = '0;
    q = 0;
    // unused pair bits drop out of the mask
    for (int i = 0; i < g_n; i++)
      for (int j = i + 1; j < g_n; j++) begin
        m[q] = it.graph_code[q];
        q++;
      end
    for (int i = 0; i < sgcf_pkg::NV; i++)
      for (int j = 0; j < sgcf_pkg::NV; j++) g_adj[i][j] = 1'b0;
    q = 0;
    for (int i = 0; i < g_n; i++)
      for (int j = i + 1; j < g_n; j++) begin
        if (m[q]) begin
          g_adj[i][j] = 1'b1;
          g_adj[j][i] = 1'b1;
        end
        q++;
      end
    for (int i = 0; i < g_n; i++) begin
      deg[i] = 0;
      for (int j = 0; j < g_n; j++) deg[i] += g_adj[i][j];
      g_sorted[i] = i;
    end
    // stable sort by degree, ties keep index order
    for (int i = 1; i < g_n; i++) begin
      v = g_sorted[i];
      k = i;
      while (k > 0 && deg[g_sorted[k-1]] > deg[v]) begin
        g_sorted[k] = g_sorted[k-1];
        k--;
      end
      g_sorted[k] = v;
    end
    lo = 0;
    for (int i = 0; i <= g_n; i++) begin
      if (i == g_n || (i > lo && deg[g_sorted[i]] != deg[g_sorted[lo]])) begin
        for (int c = lo; c < i; c++) begin
          g_lo[c] = lo;
          g_hi[c] = i;
        end
        lo = i;
      end
    end
    for (int i = 0; i < sgcf_pkg::NV; i++) g_used[i] = 1'b0;
    g_best = '1;
    g_target = m;
    g_hits = 0;
    walk_orders(0);
    r.canonical_code = g_best;
    r.automorphism_count = g_hits[sgcf_pkg::CW-1:0];
    return r;
  endfunction

  typedef struct {
    sgcf_pkg::code_t         code;
    sgcf_pkg::vtx_t          count;
    bit                      known;
    sgcf_pkg::code_t         exp_code;
    logic [sgcf_pkg::CW-1:0] exp_autos;
  } graph_row_t;

  graph_row_t graph_table[] = '{
    '{21'h1FFFFF, 3'd0, 1, 21'h0,      13'd1},    // no vertices
    '{21'h1FFFFF, 3'd1, 1, 21'h0,      13'd1},    // single vertex
    '{21'h000000, 3'd2, 1, 21'h0,      13'd2},
    '{21'h1FFFFF, 3'd2, 1, 21'h1,      13'd2},
    '{21'h000000, 3'd7, 1, 21'h0,      13'd5040}, // empty graph
    '{21'h1FFFFF, 3'd7, 1, 21'h1FFFFF, 13'd5040}, // complete graph
    '{21'h1FFFFE, 3'd7, 0, '0, '0},
    '{21'h000001, 3'd7, 0, '0, '0},
    '{21'h100000, 3'd7, 0, '0, '0},
    '{21'h0AAAAA, 3'd7, 0, '0, '0},
    '{21'h155555, 3'd7, 0, '0, '0},
    '{21'h000007, 3'd3, 0, '0, '0},
    '{21'h1FFFF8, 3'd3, 0, '0, '0},               // only ignored bits set
    '{21'h000005, 3'd3, 0, '0, '0},
    '{21'h00002D, 3'd4, 0, '0, '0},
    '{21'h00012B, 3'd5, 0, '0, '0},
    '{21'h0049A3, 3'd6, 0, '0, '0},
    '{21'h1F8000, 3'd6, 0, '0, '0},
    '{21'h03F00F, 3'd7, 0, '0, '0},
    '{21'h1C0E07, 3'd7, 0, '0, '0}
  };

  function automatic bit idle_now(bit sender);
    case (idle_phase)
      0:       return $urandom_range(99) < (sender ? 34 : 73);
      1:       return $urandom_range(99) < (sender ? 73 : 34);
      default: return 1'b0;
    endcase
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_graph(sgcf_pkg::in_item_t it, sgcf_pkg::out_item_t want);
    while (idle_now(1'b1)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    expected_labels.insert(expected_labels.size(), want);
    items_sent++;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    sgcf_pkg::in_item_t  it;
    sgcf_pkg::out_item_t want;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (graph_table[i]) begin
      it.graph_code   = graph_table[i].code;
      it.vertex_count = graph_table[i].count;
      if (graph_table[i].known) begin
        want.canonical_code     = graph_table[i].exp_code;
        want.automorphism_count = graph_table[i].exp_autos;
      end else
        want = canonical_label(it);
      send_graph(it, want);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_phase = (i < 30) ? 0 : (i < 60) ? 1 : 2;
      it.graph_code = sgcf_pkg::code_t'($urandom);
      // mostly full-size graphs, sometimes sparse or dense ones
      case ($urandom_range(3))
        0:       it.graph_code &= sgcf_pkg::code_t'($urandom);
        1:       it.graph_code |= sgcf_pkg::code_t'($urandom);
        default: ;
      endcase
      it.vertex_count = ($urandom_range(3) == 0) ? sgcf_pkg::vtx_t'($urandom_range(7))
                                                 : sgcf_pkg::vtx_t'(7);
      send_graph(it, canonical_label(it));
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  // result side stall, with one long hold-off to back the block up
  initial begin
    @(negedge clk);
    while (labels_seen < 3) begin
      out_stall <= idle_now(1'b0);
      @(negedge clk);
    end
    out_stall <= 1'b1;
    for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
    forever begin
      out_stall <= idle_now(1'b0);
      @(negedge clk);
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    sgcf_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      labels_seen++;
      if (expected_labels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        want = expected_labels.pop_front();
        if (out_item.canonical_code !== want.canonical_code ||
            out_item.automorphism_count !== want.automorphism_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: code exp %h got %h, autos exp %0d got %0d",
                     want.canonical_code, out_item.canonical_code,
                     want.automorphism_count, out_item.automorphism_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (sending_done);
    wait (expected_labels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d graphs labelled (vertex counts 0..7, edge masks from empty to complete),",
             items_sent);
    $display("%0d results checked over varied idling and one long output hold-off",
             labels_seen);
    if (mismatches == 0 && expected_labels.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
